// File: rtl/swfp_pkg.sv
// ----------------------------------------------------------------------------
// swfp_pkg: shared types and constants of the sync word frame parser
// Word kinds passed from the front to the back, header lookup, CRC step.
// ----------------------------------------------------------------------------
package swfp_pkg;

  localparam logic [31:0] SYNC_RESET = 32'h4832_42AA;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

  // Result event codes
  localparam logic [1:0] EV_DATA   = 2'd0;
  localparam logic [1:0] EV_OK     = 2'd1;
  localparam logic [1:0] EV_CRCERR = 2'd2;
  localparam logic [1:0] EV_REJECT = 2'd3;

  // Work kinds queued between the front and the back
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] ftype;
    logic [10:0] index;
    logic [31:0] rx_crc;
  } token_t;

  typedef struct packed {
    logic        known;
    logic [10:0] size;
  } size_lookup_t;

  // Expected payload size for each known frame type
  function automatic size_lookup_t size_for_type(input logic [15:0] t);
    size_lookup_t r;
    r.known = 1'b1;
    case (t)
      16'h6364: r.size = 11'd32;
      16'h6466: r.size = 11'd768;
      16'h6473: r.size = 11'd0;
      16'h6662: r.size = 11'd4;
      16'h6675: r.size = 11'd1028;
      16'h6B61: r.size = 11'd4;
      16'h6D64: r.size = 11'd0;
      16'h7276: r.size = 11'd40;
      16'h736C: r.size = 11'd16;
      16'h7374: r.size = 11'd0;
      16'h7878: r.size = 11'd0;
      default: begin
        r.known = 1'b0;
        r.size  = 11'd0;
      end
    endcase
    return r;
  endfunction

  // Reflected CRC-32 update over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: rtl/swfp_if.sv
// ----------------------------------------------------------------------------
// swfp_if: channel interfaces of the sync word frame parser
// Received byte, configuration write and result channels.
// ----------------------------------------------------------------------------
interface swfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface swfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [15:0] type_id;
  logic [10:0] byte_index;
  logic        frame_end;
  modport source (output valid, output event_res, output data_byte, output type_id,
                  output byte_index, output frame_end, input ready);
  modport sink (input valid, input event_res, input data_byte, input type_id,
                input byte_index, input frame_end, output ready);
endinterface

// File: rtl/swfp_front.sv
// ----------------------------------------------------------------------------
// swfp_front: sync hunt and header parse
// Classifies each received word and queues payload, reject and check work.
// ----------------------------------------------------------------------------
module swfp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_valid,
  input  logic [31:0]          cfg_data,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output swfp_pkg::token_t     tok
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  logic [31:0] sync_word;
  logic [2:0]  phase, phase_next;
  logic [31:0] window, window_next;
  logic [1:0]  field_cnt, field_cnt_next;
  logic [15:0] cur_type, cur_type_next;
  logic [7:0]  size_lo, size_lo_next;
  logic [10:0] pay_size, pay_size_next;
  logic [10:0] pay_cnt, pay_cnt_next;
  logic [31:0] rx_crc, rx_crc_next;

  logic                   accept;
  logic [31:0]            shifted;
  logic [10:0]            cnt_inc;
  swfp_pkg::size_lookup_t lk;

  assign in_ready = tok_ready;
  assign accept   = in_valid && in_ready;
  assign shifted  = {in_byte, window[31:8]};
  assign cnt_inc  = pay_cnt + 11'd1;
  assign lk       = swfp_pkg::size_for_type(cur_type);

  always_comb begin
    phase_next     = phase;
    window_next    = window;
    field_cnt_next = field_cnt;
    cur_type_next  = cur_type;
    size_lo_next   = size_lo;
    pay_size_next  = pay_size;
    pay_cnt_next   = pay_cnt;
    rx_crc_next    = rx_crc;
    tok_valid      = 1'b0;
    tok.kind       = swfp_pkg::KIND_DATA;
    tok.data       = in_byte;
    tok.ftype      = cur_type;
    tok.index      = pay_cnt;
    tok.rx_crc     = {in_byte, rx_crc[23:0]};
    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (shifted == sync_word) begin
            phase_next     = PH_TYPE;
            field_cnt_next = 2'd0;
            cur_type_next  = 16'd0;
            window_next    = 32'd0;
          end else begin
            window_next = shifted;
          end
        end
        PH_TYPE: begin
          if (field_cnt == 2'd0) begin
            cur_type_next  = {8'd0, in_byte};
            field_cnt_next = 2'd1;
          end else begin
            cur_type_next  = {in_byte, cur_type[7:0]};
            phase_next     = PH_SIZE;
            field_cnt_next = 2'd0;
          end
        end
        PH_SIZE: begin
          if (field_cnt == 2'd0) begin
            size_lo_next   = in_byte;
            field_cnt_next = 2'd1;
          end else begin
            field_cnt_next = 2'd0;
            if (!lk.known || {in_byte, size_lo} != {5'd0, lk.size}) begin
              tok_valid   = 1'b1;
              tok.kind    = swfp_pkg::KIND_REJECT;
              phase_next  = PH_HUNT;
              window_next = 32'd0;
            end else begin
              pay_size_next = lk.size;
              pay_cnt_next  = 11'd0;
              rx_crc_next   = 32'd0;
              phase_next    = (lk.size == 11'd0) ? PH_CRC : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          tok_valid    = 1'b1;
          tok.kind     = swfp_pkg::KIND_DATA;
          pay_cnt_next = cnt_inc;
          if (cnt_inc >= pay_size) begin
            phase_next     = PH_CRC;
            field_cnt_next = 2'd0;
          end
        end
        PH_CRC: begin
          case (field_cnt)
            2'd0: rx_crc_next = {rx_crc[31:8], in_byte};
            2'd1: rx_crc_next = {rx_crc[31:16], in_byte, rx_crc[7:0]};
            2'd2: rx_crc_next = {rx_crc[31:24], in_byte, rx_crc[15:0]};
            default: rx_crc_next = {in_byte, rx_crc[23:0]};
          endcase
          if (field_cnt != 2'd3) begin
            field_cnt_next = field_cnt + 2'd1;
          end else begin
            tok_valid      = 1'b1;
            tok.kind       = swfp_pkg::KIND_CHECK;
            phase_next     = PH_HUNT;
            window_next    = 32'd0;
            field_cnt_next = 2'd0;
          end
        end
        default: begin
          phase_next     = PH_HUNT;
          window_next    = 32'd0;
          field_cnt_next = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= swfp_pkg::SYNC_RESET;
      phase     <= PH_HUNT;
      window    <= 32'd0;
      field_cnt <= 2'd0;
      cur_type  <= 16'd0;
      size_lo   <= 8'd0;
      pay_size  <= 11'd0;
      pay_cnt   <= 11'd0;
      rx_crc    <= 32'd0;
    end else begin
      if (cfg_valid) begin
        sync_word <= cfg_data;
      end
      phase     <= phase_next;
      window    <= window_next;
      field_cnt <= field_cnt_next;
      cur_type  <= cur_type_next;
      size_lo   <= size_lo_next;
      pay_size  <= pay_size_next;
      pay_cnt   <= pay_cnt_next;
      rx_crc    <= rx_crc_next;
    end
  end

endmodule

// File: rtl/swfp_queue.sv
// ----------------------------------------------------------------------------
// swfp_queue: short work queue between front and back
// Register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module swfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  swfp_pkg::token_t push_tok,
  output logic             not_full,
  output logic             not_empty,
  input  logic             pop,
  output swfp_pkg::token_t pop_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  swfp_pkg::token_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_tok   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/swfp_back.sv
// ----------------------------------------------------------------------------
// swfp_back: CRC accumulation and result output
// Runs the payload CRC, checks the trailer and holds one result word.
// ----------------------------------------------------------------------------
module swfp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_pop,
  input  swfp_pkg::token_t tok,
  swfp_res_if.source       res
);

  logic [31:0] crc;
  logic        out_free;

  assign out_free = !res.valid || res.ready;
  assign tok_pop  = tok_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      crc       <= swfp_pkg::CRC_INIT;
    end else if (out_free) begin
      res.valid <= tok_valid;
      if (tok_valid) begin
        case (tok.kind)
          swfp_pkg::KIND_DATA: crc <= swfp_pkg::crc_byte(crc, tok.data);
          swfp_pkg::KIND_CHECK: crc <= swfp_pkg::CRC_INIT;
          default: crc <= crc;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      res.type_id <= tok.ftype;
      case (tok.kind)
        swfp_pkg::KIND_DATA: begin
          res.event_res  <= swfp_pkg::EV_DATA;
          res.data_byte  <= tok.data;
          res.byte_index <= tok.index;
          res.frame_end  <= 1'b0;
        end
        swfp_pkg::KIND_CHECK: begin
          res.event_res  <= (~crc == tok.rx_crc) ? swfp_pkg::EV_OK : swfp_pkg::EV_CRCERR;
          res.data_byte  <= 8'd0;
          res.byte_index <= 11'd0;
          res.frame_end  <= 1'b1;
        end
        default: begin
          res.event_res  <= swfp_pkg::EV_REJECT;
          res.data_byte  <= 8'd0;
          res.byte_index <= 11'd0;
          res.frame_end  <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: rtl/sync_word_frame_parser_crc32.sv
// ----------------------------------------------------------------------------
// sync_word_frame_parser_crc32: sync word deframer with CRC-32 trailer check
// Hunts for a sync word, checks type and size, passes payload out and
// reports each frame as accepted, CRC error or rejected.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          word contents
//   rx       in   rx.valid/ready     rx_byte: one received byte
//   cfg      in   cfg.valid/ready    data: sync word (always ready)
//   res      out  res.valid/ready    event_res, data_byte, type_id,
//                                    byte_index, frame_end
//
// One received word per cycle is taken; rx.ready drops only while the work
// queue is full, which happens when res is held by the sink.
// A result word is registered: the work for the byte that causes it is
// queued when that byte is taken and later loaded into the result
// register, once that register is free.
// Synchronous reset restores the sync word, returns to hunting and empties
// the queue and the result register; no clearing pass is needed.
//
module sync_word_frame_parser_crc32 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  swfp_byte_if.sink   rx,
  swfp_cfg_if.sink    cfg,
  swfp_res_if.source  res
);

  swfp_pkg::token_t f_tok;
  swfp_pkg::token_t q_tok;
  logic             f_valid;
  logic             q_not_full;
  logic             q_not_empty;
  logic             q_pop;

  // Sync word writes are always taken
  assign cfg.ready = 1'b1;

  // Front: hunt, parse header, classify payload and trailer words
  swfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_byte   (rx.rx_byte),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .tok_valid (f_valid),
    .tok_ready (q_not_full),
    .tok       (f_tok)
  );

  // Queue: decouple parsing from the result side
  swfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_tok  (f_tok),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_tok   (q_tok)
  );

  // Back: advance the CRC, compare the trailer, hold the result word
  swfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_not_empty),
    .tok_pop   (q_pop),
    .tok       (q_tok),
    .res       (res)
  );

endmodule
